[design/i2cms_pkg.sv]
package i2cms_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);

    localparam logic [8:0] DEPTH_LIM = 9'(BUFFER_DEPTH);
    localparam logic [5:0] PTR_MAX   = 6'd63;
    localparam logic [7:0] READ_BIT  = 8'h01;

    localparam logic [2:0] CMD_LOAD       = 3'd0;
    localparam logic [2:0] CMD_START_WR   = 3'd1;
    localparam logic [2:0] CMD_START_WRRD = 3'd2;
    localparam logic [2:0] CMD_BUS_EVENT  = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;
    localparam logic [2:0] CMD_FETCH      = 3'd5;

    localparam logic [2:0] ST_START      = 3'd0;
    localparam logic [2:0] ST_RESTART    = 3'd1;
    localparam logic [2:0] ST_ADDR_W_ACK = 3'd2;
    localparam logic [2:0] ST_DATA_ACK   = 3'd3;
    localparam logic [2:0] ST_ADDR_R_ACK = 3'd4;
    localparam logic [2:0] ST_RX_ACK     = 3'd5;
    localparam logic [2:0] ST_RX_NACK    = 3'd6;
    localparam logic [2:0] ST_ERROR      = 3'd7;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_RX_ACK  = 3'd3;
    localparam logic [2:0] ACT_RX_NACK = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;
    localparam logic [2:0] ACT_RESTART = 3'd6;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic [4:0] buf_index;
        logic [6:0] slave_addr;
        logic [5:0] write_len;
        logic [5:0] read_len;
        logic [7:0] delay_ms;
        logic [2:0] bus_status;
    } t_item;

    typedef struct packed {
        logic [2:0] bus_action;
        logic       from_store;
        logic [7:0] out_byte;
        logic       request_ok;
        logic       done_res;
        logic       done_error;
        logic       busy_res;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } t_store_req;

    function automatic logic [BUF_AW-1:0] buf_addr(input logic [7:0] v);
        return v[BUF_AW-1:0];
    endfunction

    function automatic logic in_buf(input logic [7:0] v);
        return {1'b0, v} < DEPTH_LIM;
    endfunction

endpackage

[design/i2cms_store.sv]
module i2cms_store
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  t_store_req i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/i2cms_ctrl.sv]
module i2cms_ctrl
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_item      i_item,
    output t_result    o_res,
    output t_store_req o_req
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_WAIT  = 2'd2,
        PH_READ  = 2'd3
    } t_phase;

    t_phase     r_phase,  n_phase;
    logic [5:0] r_ptr,    n_ptr;
    logic [5:0] r_plen,   n_plen;
    logic [5:0] r_pend,   n_pend;
    logic [7:0] r_addr,   n_addr;
    logic [7:0] r_wticks, n_wticks;
    logic [7:0] r_wleft,  n_wleft;

    logic [5:0] ptr_inc;
    logic [2:0] ack_cur;
    logic [2:0] ack_inc;
    logic       wlen_ok;
    logic       rlen_ok;
    logic       ptr_in_buf;
    logic       idx_in_buf;
    t_result    res;
    t_store_req req;

    always_comb begin
        ptr_inc    = (r_ptr < PTR_MAX) ? r_ptr + 6'd1 : r_ptr;
        ack_cur    = ({1'b0, r_ptr} + 7'd1 < {1'b0, r_plen}) ? ACT_RX_ACK : ACT_RX_NACK;
        ack_inc    = ({1'b0, ptr_inc} + 7'd1 < {1'b0, r_plen}) ? ACT_RX_ACK : ACT_RX_NACK;
        wlen_ok    = {3'b0, i_item.write_len} <= DEPTH_LIM;
        rlen_ok    = {3'b0, i_item.read_len} <= DEPTH_LIM;
        ptr_in_buf = in_buf({2'b0, r_ptr});
        idx_in_buf = in_buf({3'b0, i_item.buf_index});

        n_phase  = r_phase;
        n_ptr    = r_ptr;
        n_plen   = r_plen;
        n_pend   = r_pend;
        n_addr   = r_addr;
        n_wticks = r_wticks;
        n_wleft  = r_wleft;

        res       = '0;
        req       = '0;
        req.wdata = i_item.data_byte;

        case (i_item.cmd)
            CMD_LOAD: begin
                if (r_phase == PH_IDLE && idx_in_buf) begin
                    req.we    = 1'b1;
                    req.waddr = buf_addr({3'b0, i_item.buf_index});
                end
            end
            CMD_START_WR, CMD_START_WRRD: begin
                if (r_phase == PH_IDLE && wlen_ok &&
                    (i_item.cmd == CMD_START_WR || rlen_ok)) begin
                    n_plen = i_item.write_len;
                    n_pend = (i_item.cmd == CMD_START_WRRD) ? i_item.read_len : 6'd0;
                    if (i_item.cmd == CMD_START_WRRD) begin
                        n_wticks = i_item.delay_ms;
                    end
                    n_addr         = {i_item.slave_addr, 1'b0};
                    n_ptr          = 6'd0;
                    n_phase        = PH_WRITE;
                    res.bus_action = ACT_START;
                    res.request_ok = 1'b1;
                end
            end
            CMD_BUS_EVENT: begin
                if (r_phase == PH_WRITE || r_phase == PH_READ) begin
                    if (i_item.bus_status inside {ST_START, ST_RESTART}) begin
                        n_ptr          = 6'd0;
                        res.bus_action = ACT_SEND;
                        res.out_byte   = r_addr;
                    end else if (i_item.bus_status inside {ST_ADDR_W_ACK, ST_DATA_ACK} &&
                                 r_phase == PH_WRITE) begin
                        if (r_ptr < r_plen) begin
                            res.bus_action = ACT_SEND;
                            res.from_store = 1'b1;
                            req.raddr      = buf_addr({2'b0, r_ptr});
                            n_ptr          = ptr_inc;
                        end else if (r_pend != 6'd0) begin
                            n_plen  = r_pend;
                            n_pend  = 6'd0;
                            n_addr  = r_addr | READ_BIT;
                            n_wleft = r_wticks;
                            if (r_wticks == 8'd0) begin
                                n_phase        = PH_READ;
                                res.bus_action = ACT_RESTART;
                            end else begin
                                n_phase        = PH_WAIT;
                                res.bus_action = ACT_STOP;
                            end
                        end else begin
                            n_phase        = PH_IDLE;
                            res.bus_action = ACT_STOP;
                            res.done_res   = 1'b1;
                        end
                    end else if (i_item.bus_status == ST_ADDR_R_ACK && r_phase == PH_READ) begin
                        res.bus_action = ack_cur;
                    end else if (i_item.bus_status == ST_RX_ACK && r_phase == PH_READ) begin
                        req.we         = ptr_in_buf;
                        req.waddr      = buf_addr({2'b0, r_ptr});
                        n_ptr          = ptr_inc;
                        res.bus_action = ack_inc;
                    end else if (i_item.bus_status == ST_RX_NACK && r_phase == PH_READ) begin
                        req.we         = ptr_in_buf;
                        req.waddr      = buf_addr({2'b0, r_ptr});
                        n_phase        = PH_IDLE;
                        res.bus_action = ACT_STOP;
                        res.done_res   = 1'b1;
                    end else begin
                        n_phase        = PH_IDLE;
                        res.bus_action = ACT_STOP;
                        res.done_res   = 1'b1;
                        res.done_error = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                if (r_phase == PH_WAIT) begin
                    n_wleft = (r_wleft != 8'd0) ? r_wleft - 8'd1 : r_wleft;
                    if (n_wleft == 8'd0) begin
                        n_phase        = PH_READ;
                        res.bus_action = ACT_START;
                    end
                end
            end
            CMD_FETCH: begin
                if (r_phase == PH_IDLE && idx_in_buf) begin
                    res.from_store = 1'b1;
                    res.request_ok = 1'b1;
                    req.raddr      = buf_addr({3'b0, i_item.buf_index});
                end
            end
            default: begin
            end
        endcase

        res.busy_res = (n_phase != PH_IDLE);
        req.we       = req.we & i_adv;
        req.re       = res.from_store & i_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ptr    <= '0;
            r_plen   <= '0;
            r_pend   <= '0;
            r_addr   <= '0;
            r_wticks <= '0;
            r_wleft  <= '0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_ptr    <= n_ptr;
            r_plen   <= n_plen;
            r_pend   <= n_pend;
            r_addr   <= n_addr;
            r_wticks <= n_wticks;
            r_wleft  <= n_wleft;
        end
    end

    assign o_res = res;
    assign o_req = req;

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && res.done_res |=> r_phase == PH_IDLE)
        else $error("finished transaction did not return to idle");

    a_err_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done_error |-> res.done_res && res.bus_action == ACT_STOP)
        else $error("error flagged without stop and done");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> {3'b0, r_plen} <= DEPTH_LIM)
        else $error("phase length beyond buffer");

    a_store_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.we |-> r_phase == PH_IDLE || r_phase == PH_READ)
        else $error("buffer written during write or wait phase");

    a_wait_expires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && r_phase == PH_WAIT && i_item.cmd == CMD_TICK && r_wleft == 8'd1
        |=> r_phase == PH_READ)
        else $error("wait phase did not end on last tick");
`endif

endmodule

[design/i2c_master_write_read_sequencer_core.sv]
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: cmd; tdata: command fields
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: one result per input beat
//
// One beat per cycle unless m_axis stalls; beats pass the input and result registers.
// The input register and the result register with the buffer read port decouple the sides.
// i_rst_n (synchronous) returns the sequencer to idle; buffer contents are not cleared.
// A stalled m_axis holds one result and one pending input beat before s_axis_tready drops.
module i2c_master_write_read_sequencer_core
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] cmd
    input  logic [2:0]  s_axis_tuser,
    // [7:0] data_byte, [12:8] buf_index, [19:13] slave_addr, [25:20] write_len,
    // [31:26] read_len, [39:32] delay_ms, [42:40] bus_status, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] bus_action, [10:3] out_byte, [11] request_ok, [12] done_res,
    // [13] done_error, [14] busy_res, [15] zero
    output logic [15:0] m_axis_tdata
);

    logic       r_in_valid;
    t_item      r_item;
    logic       r_out_valid;
    t_result    r_res;
    logic       adv;
    logic       take;
    t_result    res;
    t_store_req req;
    logic [7:0] rdata;
    logic [7:0] out_byte;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.cmd        <= s_axis_tuser;
            r_item.data_byte  <= s_axis_tdata[7:0];
            r_item.buf_index  <= s_axis_tdata[12:8];
            r_item.slave_addr <= s_axis_tdata[19:13];
            r_item.write_len  <= s_axis_tdata[25:20];
            r_item.read_len   <= s_axis_tdata[31:26];
            r_item.delay_ms   <= s_axis_tdata[39:32];
            r_item.bus_status <= s_axis_tdata[42:40];
        end
        if (adv) begin
            r_res <= res;
        end
    end

    i2cms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_item),
        .o_res   (res),
        .o_req   (req)
    );

    i2cms_store u_store (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    assign out_byte      = r_res.from_store ? rdata : r_res.out_byte;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_res.busy_res, r_res.done_error, r_res.done_res,
                            r_res.request_ok, out_byte, r_res.bus_action};

endmodule
